FILE: rtl/core/pif_pkg.sv
// Shared types and codes for the priority insert queue.
// No dependencies; imported by pif_ctrl, pif_datapath and priority_insert_fifo.
package pif_pkg;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_PRIO   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] pid;
		logic [7:0]  priority_req;
	} in_item_t;

	typedef struct packed {
		logic [15:0] head_pid;
		logic [7:0]  head_priority;
		logic [15:0] tail_pid;
		logic [7:0]  tail_priority;
		logic [4:0]  count;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic [15:0] pid;
		logic [7:0]  prio;
	} entry_t;

	typedef struct packed {
		logic load;
		logic sweep_rd;
		logic sweep_put;
		logic sweep_wr;
		logic rd_head;
		logic rd_tail;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic need_sweep;
		logic at_end;
	} sts_t;

endpackage

FILE: rtl/core/pif_ctrl.sv
// Sequencer for the priority insert queue: accept, sweep, head/tail read, result.
// Depends on pif_pkg.
module pif_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  pif_pkg::sts_t sts,
	output pif_pkg::cmd_t cmd
);
	import pif_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SW_RD,
		S_SW_WR,
		S_RD_HEAD,
		S_RD_TAIL,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:    cmd.load = accept;
			S_SW_RD: begin
				cmd.sweep_put = sts.at_end;
				cmd.sweep_rd  = !sts.at_end;
			end
			S_SW_WR:   cmd.sweep_wr = 1'b1;
			S_RD_HEAD: cmd.rd_head = 1'b1;
			S_RD_TAIL: cmd.rd_tail = 1'b1;
			S_FIN:     cmd.finish = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= sts.need_sweep ? S_SW_RD : S_RD_HEAD;
					end
				end
				S_SW_RD:   state_q <= sts.at_end ? S_RD_HEAD : S_SW_WR;
				S_SW_WR:   state_q <= S_SW_RD;
				S_RD_HEAD: state_q <= S_RD_TAIL;
				S_RD_TAIL: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/pif_datapath.sv
// Entry store as a circular buffer with head pointer, count, insert sweep and result register.
// Depends on pif_pkg; commanded by pif_ctrl.
module pif_datapath #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pif_pkg::in_item_t in_item,
	input  pif_pkg::cmd_t     cmd,
	output pif_pkg::sts_t     sts,
	output pif_pkg::out_item_t out_item
);
	import pif_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	entry_t          mem_q [DEPTH];
	entry_t          rd_q;
	entry_t          head_q;
	entry_t          carry_q;
	logic            found_q;
	logic [1:0]      status_q;
	logic [AW-1:0]   hd_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   k_q;
	out_item_t       res_q;

	logic            is_enq;
	logic            full;
	logic            empty;
	logic            take;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic [CW-1:0]   tail_k;

	// Map a position counted from the head to a slot of the ring.
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] hd, input logic [CW-1:0] k);
		logic [SW-1:0] s;
		s = SW'(hd) + SW'(k);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign is_enq = (in_item.op == OP_APPEND) || (in_item.op == OP_PRIO);
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign take   = found_q || (rd_q.prio < carry_q.prio);
	assign tail_k = empty ? '0 : cnt_q - CW'(1);

	assign sts.need_sweep = is_enq && !full;
	assign sts.at_end     = (k_q == cnt_q);

	always_comb begin
		wr_en   = cmd.sweep_put || (cmd.sweep_wr && take);
		wr_addr = cmd.sweep_put ? slot(hd_q, cnt_q) : slot(hd_q, k_q);
		wr_data = carry_q;
		rd_en   = cmd.sweep_rd || cmd.rd_head || cmd.rd_tail;
		if (cmd.rd_head) begin
			rd_addr = hd_q;
		end else if (cmd.rd_tail) begin
			rd_addr = slot(hd_q, tail_k);
		end else begin
			rd_addr = slot(hd_q, k_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.load && (in_item.op == OP_REMOVE) && !empty) begin
				hd_q  <= slot(hd_q, CW'(1));
				cnt_q <= cnt_q - CW'(1);
			end else if (cmd.sweep_put) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Load, insert sweep (from the found slot, entries ripple tailward), head capture, result.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			carry_q <= '{pid: in_item.pid, prio: in_item.priority_req};
			found_q <= (in_item.op != OP_PRIO);
			k_q     <= (in_item.op == OP_PRIO) ? '0 : cnt_q;
			if (is_enq && full) begin
				status_q <= ST_FULL;
			end else if ((in_item.op == OP_REMOVE) && empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_DONE;
			end
		end
		if (cmd.sweep_wr) begin
			k_q <= k_q + CW'(1);
			if (take) begin
				carry_q <= rd_q;
				found_q <= 1'b1;
			end
		end
		if (cmd.rd_tail) begin
			head_q <= rd_q;
		end
		if (cmd.finish) begin
			res_q.count  <= 5'(cnt_q);
			res_q.status <= status_q;
			if (empty) begin
				res_q.head_pid      <= '0;
				res_q.head_priority <= '0;
				res_q.tail_pid      <= '0;
				res_q.tail_priority <= '0;
			end else begin
				res_q.head_pid      <= head_q.pid;
				res_q.head_priority <= head_q.prio;
				res_q.tail_pid      <= rd_q.pid;
				res_q.tail_priority <= rd_q.prio;
			end
		end
	end

	assign out_item = res_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_put_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_put |-> !full)
		else $error("tail write into a full queue");

	a_sweep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_wr |-> (k_q < cnt_q))
		else $error("sweep step past the tail");

endmodule

FILE: rtl/core/priority_insert_fifo.sv
// Priority insert queue. A priority insert sweeps the stored entries from the head,
// reading and then rewriting one entry at a time (states S_SW_RD and S_SW_WR);
// an append only puts the item at the tail, and a remove, no-op or dropped enqueue
// skips the sweep. One item in flight; the next is taken once the result is loaded.
// arst_n clears the count, head pointer and handshake state; entry contents
// are not cleared and are not passed to the output until written.
module priority_insert_fifo #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pif_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output pif_pkg::out_item_t out_item
);
	import pif_pkg::*;

	// Controller and datapath talk only through these two groups.
	cmd_t cmd;
	sts_t sts;

	// Sequencer: takes an item when idle, runs the sweep and the head/tail
	// reads, then loads the result register as soon as it is free. A result
	// left waiting at the output does not block the next item from entering.
	pif_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage ring, head pointer, count and the result register.
	pif_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.out_item (out_item)
	);

	// After an accept, in_ready is low in the next cycle, so a second item cannot follow at once.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while one is in flight");

endmodule
